@@ rtl/assert_macros.svh @@
// assertion macros shared by the tick-to-time rtl
// no dependencies; bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property failed in %m");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition in %m");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ rtl/ttc_pkg.sv @@
// shared types and constants for the tick-to-time converter
// no dependencies
package ttc_pkg;

  localparam int SAMPLE_W    = 64;
  localparam int TIME_W      = 64;
  localparam int FREQ_W      = 32;
  localparam int DEN_W       = 32;
  localparam int NUM_W       = 30;
  localparam int MILLI_NUM_W = 10;
  localparam int CNT_W       = 7;

  localparam logic [FREQ_W-1:0] MS_PER_SEC  = 32'd1000;
  localparam logic [FREQ_W-1:0] NS_PER_SEC  = 32'd1000000000;
  localparam logic [FREQ_W-1:0] FREQ_RESET  = 32'd1000000;

  localparam logic [CNT_W-1:0] SHORT_STEPS = CNT_W'(DEN_W);
  localparam logic [CNT_W-1:0] LONG_STEPS  = CNT_W'(SAMPLE_W);
  localparam logic [CNT_W-1:0] MUL_STEPS   = CNT_W'(NUM_W);

  // arithmetic unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
    logic short_div;
  } ttc_arith_cmd_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } ttc_arith_stat_t;

endpackage

@@ rtl/ttc_if.sv @@
// valid/ready channels for sample items and time items
// depends on ttc_pkg
interface ttc_sample_if;
  import ttc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] counter_sample;
  logic                mode;
  modport source (output valid, counter_sample, mode, input ready);
  modport sink (input valid, counter_sample, mode, output ready);
endinterface

interface ttc_time_if;
  import ttc_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] elapsed;
  logic              overflow;
  modport source (output valid, elapsed, overflow, input ready);
  modport sink (input valid, elapsed, overflow, output ready);
endinterface

@@ rtl/ttc_arith.sv @@
// shared shift-add multiplier and restoring divider, one bit per cycle
// depends on ttc_pkg and assert_macros.svh
`include "assert_macros.svh"
module ttc_arith (
  input  logic                           clk,
  input  logic                           rst,
  input  ttc_pkg::ttc_arith_cmd_t        cmd,
  input  logic [ttc_pkg::SAMPLE_W-1:0]   opa,
  input  logic [ttc_pkg::DEN_W-1:0]      opb,
  output ttc_pkg::ttc_arith_stat_t       stat,
  output logic [ttc_pkg::SAMPLE_W-1:0]   quo,
  output logic [ttc_pkg::DEN_W-1:0]      rem
);
  import ttc_pkg::*;

  logic                busy;
  logic                done;
  logic                op_div;
  logic [CNT_W-1:0]    cnt;
  logic [SAMPLE_W-1:0] acc;
  logic [SAMPLE_W-1:0] sh;
  logic [SAMPLE_W-1:0] aop;
  logic [DEN_W-1:0]    bop;

  logic [SAMPLE_W+1:0] add_x;
  logic [SAMPLE_W+1:0] add_y;
  logic [SAMPLE_W+1:0] sum;
  logic                sub;
  logic [DEN_W:0]      trial;
  logic                ge;
  logic [SAMPLE_W-1:0] acc_next;
  logic [SAMPLE_W-1:0] sh_next;

  // one adder serves both the trial subtract and the partial-product add
  always_comb begin
    trial = {acc[DEN_W-1:0], sh[SAMPLE_W-1]};
    if (op_div) begin
      add_x = (SAMPLE_W+2)'(trial);
      add_y = (SAMPLE_W+2)'(bop);
      sub   = 1'b1;
    end else begin
      add_x = {2'b00, acc};
      add_y = sh[0] ? {2'b00, aop} : '0;
      sub   = 1'b0;
    end
    sum = add_x + (add_y ^ {(SAMPLE_W+2){sub}}) + (SAMPLE_W+2)'(sub);
    ge  = ~sum[SAMPLE_W+1];
    if (op_div) begin
      acc_next = ge ? SAMPLE_W'(sum[DEN_W-1:0]) : SAMPLE_W'(trial[DEN_W-1:0]);
      sh_next  = {sh[SAMPLE_W-2:0], ge};
    end else begin
      acc_next = sum[SAMPLE_W:1];
      sh_next  = {{(SAMPLE_W-NUM_W){1'b0}}, sum[0], sh[NUM_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      op_div <= OP_MUL;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy   <= 1'b1;
        op_div <= (cmd.op == OP_DIV);
        if (cmd.op == OP_MUL) begin
          cnt <= MUL_STEPS;
        end else if (cmd.short_div) begin
          cnt <= SHORT_STEPS;
        end else begin
          cnt <= LONG_STEPS;
        end
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= '0;
      aop <= opa;
      bop <= opb;
      if (cmd.op == OP_MUL) begin
        sh <= {{(SAMPLE_W-NUM_W){1'b0}}, opb[NUM_W-1:0]};
      end else if (cmd.short_div) begin
        sh <= {opa[DEN_W-1:0], {(SAMPLE_W-DEN_W){1'b0}}};
      end else begin
        sh <= opa;
      end
    end else if (busy) begin
      acc <= acc_next;
      sh  <= sh_next;
    end
  end

  assign quo       = op_div ? sh : {acc[SAMPLE_W-NUM_W-1:0], sh[NUM_W-1:0]};
  assign rem       = acc[DEN_W-1:0];
  assign stat.done = done;
  assign stat.ovf  = |acc[SAMPLE_W-1:SAMPLE_W-NUM_W];

  `ASSERT_NEVER(a_start_while_busy, clk, rst, cmd.start && busy)
  `ASSERT_PROP(a_done_single, clk, rst, done |=> !done)
  `ASSERT_PROP(a_rem_below_divisor, clk, rst, (done && op_div) |-> (acc[DEN_W-1:0] < bop))

endmodule

@@ rtl/tick_to_time_converter.sv @@
// top level of the tick-to-time converter: sequencer, ratio state, output register
// depends on ttc_pkg, ttc_if, ttc_arith and assert_macros.svh
// Turns samples of a free-running tick counter into elapsed milliseconds
// (mode 0) or nanoseconds (mode 1). The first item after reset captures its
// sample as the start point (a zero sample is kept as all ones) and reduces
// 1000/f and 1000000000/f by their gcd, f being tick_frequency at that moment
// (zero taken as one); later writes to tick_frequency have no effect until
// reset. Each item returns (sample - start) * num / den, with the multiply
// wrapped at 64 bits and overflow set when it wrapped. Only the low
// COUNTER_WIDTH bits of the sample are used and the difference wraps at that
// width. One item is in work at a time; all arithmetic runs bit-serially on
// one shared shift/add/subtract unit. An ordinary item takes 30 multiply
// steps and 64 divide steps on that unit plus its own sequencing states. The
// first item also runs two Euclid searches, each step a short remainder on
// the same unit. The result sits in an output register, so a new item is
// taken while it waits.
`include "assert_macros.svh"
module tick_to_time_converter #(
  parameter int COUNTER_WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ttc_pkg::FREQ_W-1:0] cfg_wr_data,
  ttc_sample_if.sink                 sample_in,
  ttc_time_if.source                 time_out
);
  import ttc_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GCD   = 4'd1;
  localparam logic [3:0] S_GWAIT = 4'd2;
  localparam logic [3:0] S_NWAIT = 4'd3;
  localparam logic [3:0] S_DWAIT = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_MWAIT = 4'd6;
  localparam logic [3:0] S_QWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]               state;
  logic [FREQ_W-1:0]        tick_frequency;
  logic [COUNTER_WIDTH-1:0] start_count;
  logic [MILLI_NUM_W-1:0]   milli_num;
  logic [DEN_W-1:0]         milli_den;
  logic [NUM_W-1:0]         nano_num;
  logic [DEN_W-1:0]         nano_den;
  logic                     pass_nano;
  logic                     out_valid;

  // item payload and scratch, no reset needed
  logic [COUNTER_WIDTH-1:0] sample_q;
  logic                     mode_q;
  logic [FREQ_W-1:0]        freq_eff;
  logic [FREQ_W-1:0]        gcd_x;
  logic [FREQ_W-1:0]        gcd_y;
  logic [SAMPLE_W-1:0]      elapsed_q;
  logic                     overflow_q;
  logic                     prod_ovf;

  ttc_arith_cmd_t           ar_cmd;
  ttc_arith_stat_t          ar_stat;
  logic [SAMPLE_W-1:0]      ar_opa;
  logic [DEN_W-1:0]         ar_opb;
  logic [SAMPLE_W-1:0]      ar_quo;
  logic [DEN_W-1:0]         ar_rem;

  logic                     accept;
  logic [COUNTER_WIDTH-1:0] sample_masked;
  logic [COUNTER_WIDTH-1:0] diff;
  logic [FREQ_W-1:0]        ratio_c;
  logic [NUM_W-1:0]         sel_num;
  logic [NUM_W-1:0]         num_eff;
  logic [DEN_W-1:0]         sel_den;
  logic [DEN_W-1:0]         den_eff;
  logic                     out_free;
  logic                     waiting;

  ttc_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ar_cmd),
    .opa  (ar_opa),
    .opb  (ar_opb),
    .stat (ar_stat),
    .quo  (ar_quo),
    .rem  (ar_rem)
  );

  assign sample_in.ready = (state == S_IDLE);
  assign accept          = sample_in.valid && sample_in.ready;
  assign sample_masked   = sample_in.counter_sample[COUNTER_WIDTH-1:0];

  // difference wraps at the counter width
  assign diff    = sample_q - start_count;
  assign ratio_c = pass_nano ? NS_PER_SEC : MS_PER_SEC;
  assign sel_num = mode_q ? nano_num : NUM_W'(milli_num);
  assign num_eff = (sel_num == '0) ? NUM_W'(1) : sel_num;
  assign sel_den = mode_q ? nano_den : milli_den;
  assign den_eff = (sel_den == '0) ? DEN_W'(1) : sel_den;
  assign out_free = !out_valid || time_out.ready;

  // states that wait on the shared unit
  assign waiting = (state == S_GWAIT) || (state == S_NWAIT) || (state == S_DWAIT) ||
                   (state == S_MWAIT) || (state == S_QWAIT);

  // commands to the shared unit
  always_comb begin
    ar_cmd = '0;
    ar_opa = '0;
    ar_opb = '0;
    case (state)
      S_GCD: begin
        ar_cmd.start     = 1'b1;
        ar_cmd.op        = OP_DIV;
        ar_cmd.short_div = 1'b1;
        if (gcd_y == '0) begin
          // gcd found in x: reduce the numerator
          ar_opa = SAMPLE_W'(ratio_c);
          ar_opb = gcd_x;
        end else begin
          // one euclid step: x mod y
          ar_opa = SAMPLE_W'(gcd_x);
          ar_opb = gcd_y;
        end
      end
      S_NWAIT: begin
        if (ar_stat.done) begin
          ar_cmd.start     = 1'b1;
          ar_cmd.op        = OP_DIV;
          ar_cmd.short_div = 1'b1;
          ar_opa           = SAMPLE_W'(freq_eff);
          ar_opb           = gcd_x;
        end
      end
      S_MUL: begin
        ar_cmd.start = 1'b1;
        ar_cmd.op    = OP_MUL;
        ar_opa       = SAMPLE_W'(diff);
        ar_opb       = DEN_W'(num_eff);
      end
      S_MWAIT: begin
        if (ar_stat.done) begin
          ar_cmd.start = 1'b1;
          ar_cmd.op    = OP_DIV;
          ar_opa       = ar_quo;
          ar_opb       = den_eff;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_frequency <= FREQ_RESET;
    end else if (cfg_wr_en) begin
      tick_frequency <= cfg_wr_data;
    end
  end

  // sequencer and ratio state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      start_count <= '0;
      milli_num   <= '0;
      milli_den   <= '0;
      nano_num    <= '0;
      nano_den    <= '0;
      pass_nano   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // the output register is reloaded in S_OUT instead
      if (out_valid && time_out.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (start_count == '0) begin
              // first item: capture start and work out both ratios
              start_count <= (sample_masked == '0) ? {COUNTER_WIDTH{1'b1}}
                                                   : sample_masked;
              pass_nano   <= 1'b0;
              state       <= S_GCD;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_GCD: begin
          state <= (gcd_y == '0) ? S_NWAIT : S_GWAIT;
        end
        S_GWAIT: begin
          if (ar_stat.done) begin
            state <= S_GCD;
          end
        end
        S_NWAIT: begin
          if (ar_stat.done) begin
            if (pass_nano) begin
              nano_num <= ar_quo[NUM_W-1:0];
            end else begin
              milli_num <= ar_quo[MILLI_NUM_W-1:0];
            end
            state <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (ar_stat.done) begin
            if (pass_nano) begin
              nano_den <= ar_quo[DEN_W-1:0];
              state    <= S_MUL;
            end else begin
              milli_den <= ar_quo[DEN_W-1:0];
              pass_nano <= 1'b1;
              state     <= S_GCD;
            end
          end
        end
        S_MUL: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (ar_stat.done) begin
            state <= S_QWAIT;
          end
        end
        S_QWAIT: begin
          if (ar_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample_masked;
      mode_q   <= sample_in.mode;
      if (start_count == '0) begin
        freq_eff <= (tick_frequency == '0) ? FREQ_W'(1) : tick_frequency;
        gcd_x    <= MS_PER_SEC;
        gcd_y    <= (tick_frequency == '0) ? FREQ_W'(1) : tick_frequency;
      end
    end
    if (state == S_GWAIT && ar_stat.done) begin
      gcd_x <= gcd_y;
      gcd_y <= ar_rem;
    end
    if (state == S_DWAIT && ar_stat.done && !pass_nano) begin
      gcd_x <= NS_PER_SEC;
      gcd_y <= freq_eff;
    end
    if (state == S_MWAIT && ar_stat.done) begin
      prod_ovf <= ar_stat.ovf;
    end
    // quotient stays put in the idle unit until the output register frees up
    if (state == S_OUT && out_free) begin
      elapsed_q  <= ar_quo;
      overflow_q <= prod_ovf;
    end
  end

  assign time_out.valid    = out_valid;
  assign time_out.elapsed  = elapsed_q;
  assign time_out.overflow = overflow_q;

  `ASSERT_PROP(a_accept_leaves_idle, clk, rst, accept |=> (state != S_IDLE))
  `ASSERT_PROP(a_ratio_ready, clk, rst, (state == S_MUL) |-> (milli_den != '0 && nano_den != '0))
  `ASSERT_PROP(a_done_when_waiting, clk, rst, ar_stat.done |-> waiting)

endmodule
